// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/core/oldk_pkg.sv =====
// ----------------------------------------------------------------------------
// oldk_pkg
// Shared types and constants for the ordered list with delete by key.
// ----------------------------------------------------------------------------
`default_nettype none

package oldk_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int OP_W      = 2;
	localparam int IDENT_W   = 17;
	localparam int STATUS_W  = 3;

	localparam logic [IDENT_W-1:0] IDENT_MAX = 17'd100000;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 2'd0,
		OP_REMOVE = 2'd1,
		OP_DUMP   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_TAIL    = 3'd1,
		ST_MISSING = 3'd2,
		ST_FULL    = 3'd3,
		ST_EMPTY   = 3'd4,
		ST_RANGE   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_APP_CHK,
		S_SCAN,
		S_SHIFT,
		S_DUMP,
		S_RESP
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/core/oldk_if.sv =====
// ----------------------------------------------------------------------------
// oldk_in_if / oldk_out_if
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface oldk_in_if;
	import oldk_pkg::*;

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    op;
	logic [IDENT_W-1:0] ident;

	modport source (output valid, output op, output ident, input ready);
	modport sink   (input valid, input op, input ident, output ready);
endinterface

interface oldk_out_if;
	import oldk_pkg::*;

	logic                valid;
	logic                ready;
	logic [IDENT_W-1:0]  ident_out;
	logic [STATUS_W-1:0] status;
	logic                last;

	modport source (output valid, output ident_out, output status, output last, input ready);
	modport sink   (input valid, input ident_out, input status, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/oldk_mem.sv =====
// ----------------------------------------------------------------------------
// oldk_mem
// Identifier store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module oldk_mem #(
	parameter int DEPTH = oldk_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                        clk,
	input  wire logic                        ren,
	input  wire logic [AW-1:0]               raddr,
	output logic      [oldk_pkg::IDENT_W-1:0] rdata,
	input  wire logic                        we,
	input  wire logic [AW-1:0]               waddr,
	input  wire logic [oldk_pkg::IDENT_W-1:0] wdata
);
	import oldk_pkg::*;

	logic [IDENT_W-1:0] mem_q [DEPTH];
	logic [IDENT_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ren) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/oldk_seq.sv =====
// ----------------------------------------------------------------------------
// oldk_seq
// Sequencer: walks the store through one read port for tail check, key
// search, compaction and dump, and one shared comparator for the first two.
// ----------------------------------------------------------------------------
`default_nettype none

module oldk_seq #(
	parameter int DEPTH = oldk_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	oldk_in_if.sink                           req,
	oldk_out_if.source                        rsp,
	output logic                              mem_ren,
	output logic      [AW-1:0]                mem_raddr,
	input  wire logic [oldk_pkg::IDENT_W-1:0] mem_rdata,
	output logic                              mem_we,
	output logic      [AW-1:0]                mem_waddr,
	output logic      [oldk_pkg::IDENT_W-1:0] mem_wdata
);
	import oldk_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [CW-1:0] ONE      = CW'(1);

	state_t             state_q, state_d;
	logic [IDENT_W-1:0] id_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      ptr_q;
	logic [CW-1:0]      cidx_q;
	logic [CW-1:0]      didx_q;
	logic               rvalid_q;
	status_t            res_st_q;

	logic               out_valid_q;
	logic [IDENT_W-1:0] out_ident_q;
	status_t            out_status_q;
	logic               out_last_q;

	logic               accept, out_free, range_bad, eq;
	op_t                in_op;
	logic [CW-1:0]      cnt_last, cidx_prev;
	logic               scan_hit, scan_end, shift_done, dump_load, dump_end;
	logic               issue, set_res, cnt_inc, cnt_dec, load_out;
	status_t            res_st_d;
	logic [IDENT_W-1:0] load_ident;
	status_t            load_status;
	logic               load_last;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign in_op     = op_t'(req.op);
	assign range_bad = (req.ident > IDENT_MAX);
	assign out_free  = !out_valid_q || rsp.ready;
	assign cnt_last  = cnt_q - ONE;
	assign cidx_prev = cidx_q - ONE;

	// shared comparator: tail check and key search
	assign eq = (mem_rdata == id_q);

	assign scan_hit   = (state_q == S_SCAN) && rvalid_q && eq;
	assign scan_end   = (state_q == S_SCAN) && rvalid_q && !eq && (cidx_q == cnt_last);
	assign shift_done = (state_q == S_SHIFT) && (ptr_q == cnt_q) && !rvalid_q;
	assign dump_load  = (state_q == S_DUMP) && rvalid_q && out_free;
	assign dump_end   = dump_load && (didx_q == cnt_last);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (in_op)
						OP_APPEND: state_d = range_bad ? S_RESP : S_APP_CHK;
						OP_REMOVE: state_d = (range_bad || cnt_q == '0) ? S_RESP : S_SCAN;
						OP_DUMP:   state_d = (cnt_q == '0) ? S_RESP : S_DUMP;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_APP_CHK: state_d = S_RESP;
			S_SCAN: begin
				if (scan_hit) begin
					state_d = S_SHIFT;
				end else if (scan_end) begin
					state_d = S_RESP;
				end
			end
			S_SHIFT: begin
				if (shift_done) begin
					state_d = S_RESP;
				end
			end
			S_DUMP: begin
				if (dump_end) begin
					state_d = S_IDLE;
				end
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control strobes
	always_comb begin
		mem_ren     = 1'b0;
		mem_raddr   = ptr_q[AW-1:0];
		mem_we      = 1'b0;
		mem_waddr   = cnt_q[AW-1:0];
		mem_wdata   = id_q;
		issue       = 1'b0;
		set_res     = 1'b0;
		res_st_d    = ST_OK;
		cnt_inc     = 1'b0;
		cnt_dec     = 1'b0;
		load_out    = 1'b0;
		load_ident  = '0;
		load_status = res_st_q;
		load_last   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					set_res = 1'b1;
					unique case (in_op)
						OP_APPEND: begin
							// fetch the tail entry for the equality check
							mem_ren   = 1'b1;
							mem_raddr = cnt_last[AW-1:0];
							res_st_d  = ST_RANGE;
						end
						OP_REMOVE: res_st_d = range_bad ? ST_RANGE : ST_MISSING;
						OP_DUMP:   res_st_d = ST_EMPTY;
						default:   res_st_d = ST_OK;
					endcase
				end
			end
			S_APP_CHK: begin
				set_res = 1'b1;
				if (cnt_q != '0 && eq) begin
					res_st_d = ST_TAIL;
				end else if (cnt_q == FULL_CNT) begin
					res_st_d = ST_FULL;
				end else begin
					res_st_d = ST_OK;
					mem_we   = 1'b1;
					cnt_inc  = 1'b1;
				end
			end
			S_SCAN: begin
				issue   = (ptr_q < cnt_q) && !scan_hit;
				mem_ren = issue;
				if (scan_end) begin
					set_res  = 1'b1;
					res_st_d = ST_MISSING;
				end
			end
			S_SHIFT: begin
				// read the next entry while writing the one fetched before, entry j+1, to j
				issue     = (ptr_q < cnt_q);
				mem_ren   = issue;
				mem_we    = rvalid_q;
				mem_waddr = cidx_prev[AW-1:0];
				mem_wdata = mem_rdata;
				if (shift_done) begin
					set_res  = 1'b1;
					res_st_d = ST_OK;
					cnt_dec  = 1'b1;
				end
			end
			S_DUMP: begin
				issue       = (ptr_q < cnt_q) && (!rvalid_q || dump_load);
				mem_ren     = issue;
				load_out    = dump_load;
				load_ident  = mem_rdata;
				load_status = ST_OK;
				load_last   = dump_end;
			end
			S_RESP: begin
				load_out = out_free;
			end
			default: begin
				load_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ptr_q       <= '0;
			cidx_q      <= '0;
			didx_q      <= '0;
			rvalid_q    <= 1'b0;
			res_st_q    <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cnt_inc) begin
				cnt_q <= cnt_q + ONE;
			end else if (cnt_dec) begin
				cnt_q <= cnt_last;
			end

			if (state_q == S_IDLE) begin
				ptr_q <= '0;
			end else if (scan_hit) begin
				ptr_q <= cidx_q + ONE;
			end else if (issue) begin
				ptr_q <= ptr_q + ONE;
			end

			if (issue) begin
				cidx_q <= ptr_q;
			end

			// read data stays valid in dump until the output slot takes it
			rvalid_q <= issue || ((state_q == S_DUMP) && rvalid_q && !dump_load);

			if (state_q == S_IDLE) begin
				didx_q <= '0;
			end else if (dump_load) begin
				didx_q <= didx_q + ONE;
			end

			if (set_res) begin
				res_st_q <= res_st_d;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q <= req.ident;
		end
		if (load_out) begin
			out_ident_q  <= load_ident;
			out_status_q <= load_status;
			out_last_q   <= load_last;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.ident_out = out_ident_q;
	assign rsp.status    = out_status_q;
	assign rsp.last      = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/ordered_list_delete_by_key.sv =====
// ----------------------------------------------------------------------------
// ordered_list_delete_by_key
// Ordered identifier list with append, remove by key and in-order dump.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation item (op, ident); rsp returns result items
//   (ident_out, status, last). Both are valid/ready channels.
//   Append checks the tail entry, then gives one result.
//   Remove with a hit at entry i searches up to i, compacts the entries
//   above i, then gives one result; a miss searches the whole list first.
//   Dump streams count results, one per cycle while rsp is ready, last
//   set on the final one; an empty list gives a single empty result.
//   Out-of-range identifiers and empty removes go straight to the result.
//   Items that walk the whole store take longest (a remove that hits the
//   first entry of a full list, for one), since every entry passes the
//   single read port of the store.
//   req.ready is high only while the sequencer is idle.
//   If rsp stalls, the sequencer holds in place until the output register
//   frees; no result is dropped.
//   Reset empties the list at once; store contents are not cleared and
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_delete_by_key #(
	parameter int DEPTH = oldk_pkg::DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	oldk_in_if.sink    req,
	oldk_out_if.source rsp
);
	import oldk_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic               mem_ren, mem_we;
	logic [AW-1:0]      mem_raddr, mem_waddr;
	logic [IDENT_W-1:0] mem_rdata, mem_wdata;

	oldk_seq #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.mem_ren   (mem_ren),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata)
	);

	oldk_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.ren   (mem_ren),
		.raddr (mem_raddr),
		.rdata (mem_rdata),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata)
	);

endmodule

`default_nettype wire

// ===== rtl/core/oldk_chk.sv =====
// ----------------------------------------------------------------------------
// oldk_chk
// Port-level checks for the ordered list, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module oldk_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          req_valid,
	input wire logic                          req_ready,
	input wire logic [oldk_pkg::OP_W-1:0]     req_op,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic [oldk_pkg::IDENT_W-1:0]  rsp_ident_out,
	input wire logic [oldk_pkg::STATUS_W-1:0] rsp_status,
	input wire logic                          rsp_last
);
	import oldk_pkg::*;

	// a stalled result stays offered
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)

	// any error result ends its item
	`ASSERT_IMPLY(a_err_last, clk, arst_n, rsp_valid && rsp_status != ST_OK, rsp_last)

	// error results carry no identifier
	`ASSERT_IMPLY(a_err_ident, clk, arst_n, rsp_valid && rsp_status != ST_OK, rsp_ident_out == '0)

	// accepting a real operation makes the block busy in the next cycle
	`ASSERT_NEXT(a_busy, clk, arst_n, req_valid && req_ready && req_op != OP_NONE, !req_ready)

endmodule

bind ordered_list_delete_by_key oldk_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_op        (req.op),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_ident_out (rsp.ident_out),
	.rsp_status    (rsp.status),
	.rsp_last      (rsp.last)
);

`default_nettype wire

// ===== tb/ordered_list_delete_by_key_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_list_delete_by_key_check
// Watches the request and result channels, keeps a shadow copy of the
// identifier list, predicts every result item and compares it with the block.
// ----------------------------------------------------------------------------

module ordered_list_delete_by_key_check #(
	parameter int DEPTH = oldk_pkg::DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	oldk_in_if   req,
	oldk_out_if  rsp,
	output int   fails,
	output int   pending
);
	import oldk_pkg::*;

	typedef struct packed {
		logic [IDENT_W-1:0] ident;
		status_t            status;
		logic               last;
	} result_t;

	result_t            expected_q[$];
	logic [IDENT_W-1:0] list_ids [DEPTH];
	int                 list_len = 0;

	initial begin
		fails   = 0;
		pending = 0;
	end

	// Apply one operation to the shadow list and queue the results it causes.
	function automatic void apply_op(input op_t op, input logic [IDENT_W-1:0] id);
		status_t st;
		int      hit;
		int      i;
		hit = -1;
		st  = ST_OK;
		if (op == OP_APPEND || op == OP_REMOVE) begin
			if (id > IDENT_MAX) begin
				st = ST_RANGE;
			end else if (op == OP_APPEND) begin
				// tail match wins over full
				if (list_len > 0 && list_ids[list_len-1] == id) begin
					st = ST_TAIL;
				end else if (list_len >= DEPTH) begin
					st = ST_FULL;
				end else begin
					list_ids[list_len] = id;
					list_len++;
				end
			end else begin
				for (i = 0; i < list_len; i++)
					if (hit < 0 && list_ids[i] == id)
						hit = i;
				if (hit < 0) begin
					st = ST_MISSING;
				end else begin
					for (i = hit; i < list_len - 1; i++)
						list_ids[i] = list_ids[i+1];
					list_len--;
				end
			end
			expected_q.push_back('{ident: '0, status: st, last: 1'b1});
		end else if (op == OP_DUMP) begin
			if (list_len == 0)
				expected_q.push_back('{ident: '0, status: ST_EMPTY, last: 1'b1});
			for (i = 0; i < list_len; i++)
				expected_q.push_back('{ident: list_ids[i], status: ST_OK,
					last: (i == list_len - 1)});
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			// results first: a result never comes from an item taken at this edge
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					fails++;
					$display("%0t: result with nothing expected: ident_out=%0d status=%0d last=%0d",
						$time, rsp.ident_out, rsp.status, rsp.last);
				end else begin
					want = expected_q.pop_front();
					if (rsp.ident_out !== want.ident) begin
						fails++;
						$display("%0t: ident_out expected %0d actual %0d",
							$time, want.ident, rsp.ident_out);
					end
					if (rsp.status !== want.status) begin
						fails++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, rsp.status);
					end
					if (rsp.last !== want.last) begin
						fails++;
						$display("%0t: last expected %0d actual %0d",
							$time, want.last, rsp.last);
					end
				end
			end
			if (req.valid && req.ready)
				apply_op(op_t'(req.op), req.ident);
			pending = expected_q.size();
		end
	end

endmodule

// ===== tb/ordered_list_delete_by_key_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_list_delete_by_key_test
// Drives append, remove and dump items into the list with random gaps and
// result stalls, fills the store to full, and reports the checker's verdict.
// ----------------------------------------------------------------------------

module ordered_list_delete_by_key_test;
	import oldk_pkg::*;

	localparam int DEPTH        = DEPTH_DEF;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 2 * DEPTH + 16;
	localparam int HOLD_CYCLES  = 400;
	localparam int MIXED_A      = 60;
	localparam int MIXED_C      = 53;

	logic clk;
	logic arst_n;
	int   fails;
	int   pending;
	int   cycles;
	bit   idle_on;
	int   hold_grants;
	logic [IDENT_W-1:0] recent_ids [16];
	int   recent_wr;

	oldk_in_if  req ();
	oldk_out_if rsp ();

	ordered_list_delete_by_key #(.DEPTH(DEPTH)) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	ordered_list_delete_by_key_check #(.DEPTH(DEPTH)) list_check (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.fails  (fails),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// Result side: random stalls, plus a long hold-off on request.
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_grants != hold_seen) begin
				hold_seen = hold_grants;
				hold_left = HOLD_CYCLES;
			end
			if (!arst_n) begin
				rsp.ready = 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				rsp.ready = 1'b0;
			end else begin
				rsp.ready = !(idle_on && $urandom_range(0, 99) < 8);
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance
	// with valid still high, so back-to-back items keep valid high unless a random gap is drawn.
	task automatic send_item(input op_t op, input logic [IDENT_W-1:0] id);
		while (idle_on && $urandom_range(0, 99) < 8) begin
			req.valid = 1'b0;
			@(negedge clk);
		end
		req.op    = op;
		req.ident = id;
		req.valid = 1'b1;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	task automatic random_item(input int pct_append, input int pct_remove);
		op_t                op;
		logic [IDENT_W-1:0] id;
		int                 r;
		int                 s;
		r = $urandom_range(0, 99);
		s = $urandom_range(0, 99);
		if (s < 8)
			id = IDENT_W'($urandom_range(100001, 131071));
		else if (s < 22)
			id = IDENT_W'($urandom_range(0, 100000));
		else if (s < 34)
			id = IDENT_W'($urandom_range(0, 7));
		else if (s < 42)
			id = 17'd65536 + IDENT_W'($urandom_range(0, 34464));
		else
			id = recent_ids[$urandom_range(0, 15)];
		if (r < pct_append)
			op = OP_APPEND;
		else if (r < pct_append + pct_remove)
			op = OP_REMOVE;
		else if (r < 96)
			op = OP_DUMP;
		else
			op = OP_NONE;
		// remember appended ids so later removes and tail repeats hit
		if (op == OP_APPEND && id <= IDENT_MAX) begin
			recent_ids[recent_wr] = id;
			recent_wr = (recent_wr + 1) % 16;
		end
		send_item(op, id);
	endtask

	task automatic wait_drained();
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		logic [IDENT_W-1:0] prev_id;
		logic [IDENT_W-1:0] id;
		int                 i;
		arst_n      = 1'b0;
		req.valid   = 1'b0;
		req.op      = OP_NONE;
		req.ident   = '0;
		idle_on     = 1'b1;
		hold_grants = 0;
		recent_wr   = 0;
		prev_id     = '0;
		for (i = 0; i < 16; i++)
			recent_ids[i] = i[IDENT_W-1:0];
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty cases, range edges, zero id, tail rule, first/last removes
		send_item(OP_DUMP,   IDENT_W'($urandom));
		send_item(OP_REMOVE, 17'd5);
		send_item(OP_APPEND, 17'd0);
		send_item(OP_APPEND, 17'd0);
		send_item(OP_APPEND, IDENT_MAX);
		send_item(OP_APPEND, IDENT_MAX + 17'd1);
		send_item(OP_REMOVE, 17'h1FFFF);
		send_item(OP_APPEND, 17'd1);
		send_item(OP_APPEND, 17'd0);
		send_item(OP_DUMP,   17'h1FFFF);
		send_item(OP_REMOVE, 17'd0);
		send_item(OP_REMOVE, 17'd0);
		send_item(OP_REMOVE, 17'd7);
		send_item(OP_NONE,   IDENT_W'($urandom));
		send_item(OP_DUMP,   17'd0);
		send_item(OP_APPEND, 17'd65536);
		send_item(OP_REMOVE, IDENT_MAX);
		send_item(OP_REMOVE, 17'd65536);
		send_item(OP_REMOVE, 17'd1);
		send_item(OP_DUMP,   17'd0);

		for (i = 0; i < MIXED_A; i++)
			random_item(45, 30);

		// result side holds off while items keep coming
		hold_grants++;
		for (i = 0; i < 6; i++)
			random_item(60, 10);

		req.valid = 1'b0;
		wait_drained();

		// no idling: fill the store past full, then dump it whole
		idle_on = 1'b0;
		for (i = 0; i < 68; i++) begin
			id = IDENT_W'($urandom_range(0, 100000));
			if (id == prev_id)
				id = (id == 0) ? 17'd1 : id - 17'd1;
			send_item(OP_APPEND, id);
			recent_ids[recent_wr] = id;
			recent_wr = (recent_wr + 1) % 16;
			prev_id = id;
		end
		send_item(OP_APPEND, prev_id);
		send_item(OP_DUMP, IDENT_W'($urandom));
		idle_on = 1'b1;

		for (i = 0; i < MIXED_C; i++)
			random_item(30, 50);
		send_item(OP_DUMP, IDENT_W'($urandom));

		req.valid = 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fails == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== ordered_list_delete_by_key.f =====
+incdir+rtl/core
rtl/core/oldk_pkg.sv
rtl/core/oldk_if.sv
rtl/core/oldk_mem.sv
rtl/core/oldk_seq.sv
rtl/core/ordered_list_delete_by_key.sv
rtl/core/oldk_chk.sv
tb/ordered_list_delete_by_key_check.sv
tb/ordered_list_delete_by_key_test.sv
